FILE: rtl/assert_macros.svh
// Assertion helpers; clk and rst_n must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ghtm_pkg.sv
`timescale 1ns / 1ps

package ghtm_pkg;

  localparam int MAX_RECO_DEF = 32;
  localparam int MAX_SIM_DEF  = 32;
  localparam int POS_W_DEF    = 20;

  localparam int CUT_W       = 20;
  localparam int PLANE_W     = 4;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 5;
  localparam int DIST_W      = 21;
  localparam int MAX_RESULTS = 32;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_LOAD_RECO = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SIM  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

  localparam logic [1:0] REG_DUT_PLANE = 2'd0;
  localparam logic [1:0] REG_CUT_U     = 2'd1;
  localparam logic [1:0] REG_CUT_V     = 2'd2;

  localparam logic [PLANE_W-1:0] PLANE_RST = 4'd3;
  localparam logic [CUT_W-1:0]   CUT_RST   = 20'd200;

  typedef struct packed {
    logic [PLANE_W-1:0] dut_plane;
    logic [CUT_W-1:0]   cut_u;
    logic [CUT_W-1:0]   cut_v;
  } cfg_t;

endpackage

FILE: rtl/ghtm_in_if.sv
`timescale 1ns / 1ps

interface ghtm_in_if import ghtm_pkg::*; #(
  parameter int POS_WIDTH = POS_W_DEF
);
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            cmd;
  logic [PLANE_W-1:0]          plane;
  logic signed [POS_WIDTH-1:0] pos_u;
  logic signed [POS_WIDTH-1:0] pos_v;

  modport source (output valid, cmd, plane, pos_u, pos_v, input ready);
  modport sink   (input valid, cmd, plane, pos_u, pos_v, output ready);
endinterface

FILE: rtl/ghtm_out_if.sv
`timescale 1ns / 1ps

interface ghtm_out_if import ghtm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  hit_index;
  logic              matched;
  logic [IDX_W-1:0]  sim_index;
  logic [DIST_W-1:0] distance;
  logic              overflow;
  logic              last;

  modport source (output valid, hit_index, matched, sim_index, distance, overflow, last,
                  input ready);
  modport sink   (input valid, hit_index, matched, sim_index, distance, overflow, last,
                  output ready);
endinterface

FILE: rtl/ghtm_cfg.sv
`timescale 1ns / 1ps

module ghtm_cfg import ghtm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dut_plane <= PLANE_RST;
      cfg_r.cut_u     <= CUT_RST;
      cfg_r.cut_v     <= CUT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DUT_PLANE: cfg_r.dut_plane <= pwdata[PLANE_W-1:0];
        REG_CUT_U:     cfg_r.cut_u     <= pwdata[CUT_W-1:0];
        REG_CUT_V:     cfg_r.cut_v     <= pwdata[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DUT_PLANE: prdata = PDATA_W'(cfg_r.dut_plane);
      REG_CUT_U:     prdata = PDATA_W'(cfg_r.cut_u);
      REG_CUT_V:     prdata = PDATA_W'(cfg_r.cut_v);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ghtm_store.sv
`timescale 1ns / 1ps

module ghtm_store import ghtm_pkg::*; #(
  parameter int DEPTH     = MAX_RECO_DEF,
  parameter int POS_WIDTH = POS_W_DEF,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic signed [POS_WIDTH-1:0] wr_u,
  input  logic signed [POS_WIDTH-1:0] wr_v,
  input  logic [AW-1:0]               rd_addr,
  output logic signed [POS_WIDTH-1:0] rd_u,
  output logic signed [POS_WIDTH-1:0] rd_v
);

  // u in the upper half, v in the lower half
  logic [2*POS_WIDTH-1:0] mem [DEPTH];
  logic [2*POS_WIDTH-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_u, wr_v};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_u = rd_q_r[2*POS_WIDTH-1:POS_WIDTH];
  assign rd_v = rd_q_r[POS_WIDTH-1:0];

endmodule

FILE: rtl/ghtm_dist.sv
`timescale 1ns / 1ps

module ghtm_dist import ghtm_pkg::*; #(
  parameter int POS_WIDTH = POS_W_DEF
) (
  input  logic                        clk,
  input  logic signed [POS_WIDTH-1:0] a_u,
  input  logic signed [POS_WIDTH-1:0] a_v,
  input  logic signed [POS_WIDTH-1:0] b_u,
  input  logic signed [POS_WIDTH-1:0] b_v,
  input  logic [CUT_W-1:0]            cut_u,
  input  logic [CUT_W-1:0]            cut_v,
  output logic                        qual,
  output logic [POS_WIDTH:0]          l1_sum,
  output logic [DIST_W-1:0]           dist_sat
);

  localparam int CMPW = (POS_WIDTH > CUT_W) ? POS_WIDTH : CUT_W;
  localparam int EW   = (POS_WIDTH + 1 > DIST_W) ? POS_WIDTH + 1 : DIST_W;

  logic [POS_WIDTH:0]   du_ab, du_ba, dv_ab, dv_ba;
  logic [POS_WIDTH-1:0] du_nxt, dv_nxt;
  logic [POS_WIDTH-1:0] du_r, dv_r;
  logic                 en_u, en_v, rej_u, rej_v;
  logic [EW-1:0]        dist_ext;

  // stage 1: absolute residuals, both subtraction orders in parallel
  assign du_ab  = {a_u[POS_WIDTH-1], a_u} - {b_u[POS_WIDTH-1], b_u};
  assign du_ba  = {b_u[POS_WIDTH-1], b_u} - {a_u[POS_WIDTH-1], a_u};
  assign dv_ab  = {a_v[POS_WIDTH-1], a_v} - {b_v[POS_WIDTH-1], b_v};
  assign dv_ba  = {b_v[POS_WIDTH-1], b_v} - {a_v[POS_WIDTH-1], a_v};
  assign du_nxt = du_ab[POS_WIDTH] ? du_ba[POS_WIDTH-1:0] : du_ab[POS_WIDTH-1:0];
  assign dv_nxt = dv_ab[POS_WIDTH] ? dv_ba[POS_WIDTH-1:0] : dv_ab[POS_WIDTH-1:0];

  always_ff @(posedge clk) begin
    du_r <= du_nxt;
    dv_r <= dv_nxt;
  end

  // stage 2: cuts and L1 sum over enabled axes
  assign en_u   = (cut_u != '0);
  assign en_v   = (cut_v != '0);
  assign rej_u  = en_u & (CMPW'(du_r) >= CMPW'(cut_u));
  assign rej_v  = en_v & (CMPW'(dv_r) >= CMPW'(cut_v));
  assign qual   = ~rej_u & ~rej_v;
  assign l1_sum = (en_u ? {1'b0, du_r} : '0) + (en_v ? {1'b0, dv_r} : '0);

  assign dist_ext = EW'(l1_sum);
  assign dist_sat = (dist_ext > EW'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];

endmodule

FILE: rtl/greedy_hit_truth_matcher.sv
`timescale 1ns / 1ps
// Greedy hit-to-truth matcher, L1 metric, 1 um per LSB.
// in_ch  : valid/ready words {cmd, plane, pos_u, pos_v}. cmd 0 stores a
//          reconstructed hit, 1 a simulated hit (both only on plane
//          dut_plane), 2 runs the match; other codes are dropped.
// out_ch : valid/ready words {hit_index, matched, sim_index, distance,
//          overflow, last}, one per stored reconstructed hit after a run.
// APB    : reg 0 dut_plane, reg 1 u cut, reg 2 v cut (byte addr 4*i).
// A run scans every reco/sim pair through one shared distance unit, one
// pair per cycle (no scan when no sim hit is stored), then emits each
// result word via S_EMIT_RD and S_EMIT_LD, waiting while the receiver stalls.
// in_ch.ready is low for the whole run.
// The final result word sits in the output register; new loads are taken
// while it waits. After a run both stores and the overflow flag are empty.
// Reset clears counts, flags and the registers to their defaults; the
// position stores need no clearing pass.
module greedy_hit_truth_matcher import ghtm_pkg::*; #(
  parameter int MAX_RECO_HITS = MAX_RECO_DEF,
  parameter int MAX_SIM_HITS  = MAX_SIM_DEF,
  parameter int POS_WIDTH     = POS_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  ghtm_in_if.sink            in_ch,
  ghtm_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

`include "assert_macros.svh"

  localparam int RIW = (MAX_RECO_HITS > 1) ? $clog2(MAX_RECO_HITS) : 1;
  localparam int SIW = (MAX_SIM_HITS > 1) ? $clog2(MAX_SIM_HITS) : 1;
  localparam int RCW = $clog2(MAX_RECO_HITS + 1);
  localparam int SCW = $clog2(MAX_SIM_HITS + 1);
  localparam int RCX = (RCW > 7) ? RCW : 7;
  localparam int DW  = POS_WIDTH + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_EMIT_RD = 3'd3;
  localparam logic [2:0] S_EMIT_LD = 3'd4;

  cfg_t cfg;

  ghtm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // control state
  logic [2:0]     state_r, state_nxt;
  logic [RCW-1:0] rc_r, rc_nxt;
  logic [SCW-1:0] sc_r, sc_nxt;
  logic           ovf_r, ovf_nxt;
  logic [RIW-1:0] si_r, si_nxt;
  logic [SIW-1:0] sj_r, sj_nxt;
  logic [RIW-1:0] k_r, k_nxt;

  // scan pipeline tags: p1 = store read data, p2 = distance unit output
  logic           p1_valid_r, p1_first_r, p1_last_r;
  logic [RIW-1:0] p1_i_r;
  logic [SIW-1:0] p1_j_r;
  logic           p2_valid_r, p2_first_r, p2_last_r;
  logic [RIW-1:0] p2_i_r;
  logic [SIW-1:0] p2_j_r;

  // running best of the current row
  logic              best_found_r;
  logic [DW-1:0]     best_d_r;
  logic [SIW-1:0]    best_j_r;
  logic [DIST_W-1:0] best_dsat_r;

  logic [MAX_RECO_HITS-1:0] flag_r;
  logic [SIW+DIST_W-1:0]    match_mem [MAX_RECO_HITS];
  logic [SIW+DIST_W-1:0]    match_rd_r;

  // output word register
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_hit_r;
  logic              out_matched_r;
  logic [IDX_W-1:0]  out_sim_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_ovf_r;
  logic              out_last_r;

  // input handshake and load decode
  logic acc, plane_hit, reco_full, sim_full, is_reco, is_sim;
  logic reco_we, sim_we, run_acc, load_drop;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc       = in_ch.valid & in_ch.ready;
  assign plane_hit = (in_ch.plane == cfg.dut_plane);
  assign reco_full = (rc_r == RCW'(MAX_RECO_HITS));
  assign sim_full  = (sc_r == SCW'(MAX_SIM_HITS));
  assign is_reco   = acc & (in_ch.cmd == CMD_LOAD_RECO) & plane_hit;
  assign is_sim    = acc & (in_ch.cmd == CMD_LOAD_SIM) & plane_hit;
  assign reco_we   = is_reco & ~reco_full;
  assign sim_we    = is_sim & ~sim_full;
  assign load_drop = (is_reco & reco_full) | (is_sim & sim_full);
  assign run_acc   = acc & (in_ch.cmd == CMD_RUN);

  logic signed [POS_WIDTH-1:0] reco_u, reco_v, sim_u, sim_v;

  ghtm_store #(
    .DEPTH     (MAX_RECO_HITS),
    .POS_WIDTH (POS_WIDTH)
  ) u_reco_store (
    .clk     (clk),
    .wr_en   (reco_we),
    .wr_addr (rc_r[RIW-1:0]),
    .wr_u    (in_ch.pos_u),
    .wr_v    (in_ch.pos_v),
    .rd_addr (si_r),
    .rd_u    (reco_u),
    .rd_v    (reco_v)
  );

  ghtm_store #(
    .DEPTH     (MAX_SIM_HITS),
    .POS_WIDTH (POS_WIDTH)
  ) u_sim_store (
    .clk     (clk),
    .wr_en   (sim_we),
    .wr_addr (sc_r[SIW-1:0]),
    .wr_u    (in_ch.pos_u),
    .wr_v    (in_ch.pos_v),
    .rd_addr (sj_r),
    .rd_u    (sim_u),
    .rd_v    (sim_v)
  );

  logic              p2_qual;
  logic [DW-1:0]     p2_d;
  logic [DIST_W-1:0] p2_dsat;

  ghtm_dist #(
    .POS_WIDTH (POS_WIDTH)
  ) u_dist (
    .clk      (clk),
    .a_u      (reco_u),
    .a_v      (reco_v),
    .b_u      (sim_u),
    .b_v      (sim_v),
    .cut_u    (cfg.cut_u),
    .cut_v    (cfg.cut_v),
    .qual     (p2_qual),
    .l1_sum   (p2_d),
    .dist_sat (p2_dsat)
  );

  // Row evaluation. Sims are reusable, so each reco hit simply keeps its
  // own first minimum; that is exactly what the greedy rounds converge to.
  logic              cand, row_done, row_found;
  logic [SIW-1:0]    row_j;
  logic [DIST_W-1:0] row_dsat;

  assign cand      = p2_valid_r & p2_qual &
                     (p2_first_r | ~best_found_r | (p2_d < best_d_r));
  assign row_found = cand | (~p2_first_r & best_found_r);
  assign row_j     = cand ? p2_j_r : best_j_r;
  assign row_dsat  = cand ? p2_dsat : best_dsat_r;
  assign row_done  = p2_valid_r & p2_last_r;

  // scan address sequencing
  logic issue, si_last, sj_last;

  assign issue   = (state_r == S_SCAN);
  assign si_last = ((RCW'(si_r) + RCW'(1)) == rc_r);
  assign sj_last = ((SCW'(sj_r) + SCW'(1)) == sc_r);

  // emit bookkeeping: at most MAX_RESULTS words per run
  logic [RCX-1:0] rcx, emit_n, k_inc;
  logic           k_end, out_free, out_load;

  assign rcx      = RCX'(rc_r);
  assign emit_n   = (rcx > RCX'(MAX_RESULTS)) ? RCX'(MAX_RESULTS) : rcx;
  assign k_inc    = RCX'(k_r) + RCX'(1);
  assign k_end    = (k_inc == emit_n);
  assign out_free = ~out_valid_r | out_ch.ready;
  assign out_load = (state_r == S_EMIT_LD) & out_free;

  always_comb begin
    state_nxt = state_r;
    rc_nxt    = rc_r;
    sc_nxt    = sc_r;
    ovf_nxt   = ovf_r | load_drop;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    k_nxt     = k_r;
    if (reco_we) begin
      rc_nxt = rc_r + RCW'(1);
    end
    if (sim_we) begin
      sc_nxt = sc_r + SCW'(1);
    end
    case (state_r)
      S_IDLE: begin
        if (run_acc) begin
          si_nxt = '0;
          sj_nxt = '0;
          k_nxt  = '0;
          if (rc_r == '0) begin
            // nothing to report, just empty the event
            rc_nxt  = '0;
            sc_nxt  = '0;
            ovf_nxt = 1'b0;
          end else if (sc_r == '0) begin
            state_nxt = S_EMIT_RD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sj_last) begin
          sj_nxt = '0;
          if (si_last) begin
            state_nxt = S_DRAIN;
          end else begin
            si_nxt = si_r + RIW'(1);
          end
        end else begin
          sj_nxt = sj_r + SIW'(1);
        end
      end
      S_DRAIN: begin
        if (!p1_valid_r && !p2_valid_r) begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          if (k_end) begin
            state_nxt = S_IDLE;
            rc_nxt    = '0;
            sc_nxt    = '0;
            ovf_nxt   = 1'b0;
          end else begin
            k_nxt     = k_r + RIW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rc_r         <= '0;
      sc_r         <= '0;
      ovf_r        <= 1'b0;
      si_r         <= '0;
      sj_r         <= '0;
      k_r          <= '0;
      p1_valid_r   <= 1'b0;
      p2_valid_r   <= 1'b0;
      best_found_r <= 1'b0;
      flag_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rc_r       <= rc_nxt;
      sc_r       <= sc_nxt;
      ovf_r      <= ovf_nxt;
      si_r       <= si_nxt;
      sj_r       <= sj_nxt;
      k_r        <= k_nxt;
      p1_valid_r <= issue;
      p2_valid_r <= p1_valid_r;
      if (p2_valid_r) begin
        best_found_r <= row_found;
      end
      if (run_acc) begin
        flag_r <= '0;
      end else if (row_done && row_found) begin
        flag_r[p2_i_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p1_first_r <= (sj_r == '0);
    p1_last_r  <= sj_last;
    p1_i_r     <= si_r;
    p1_j_r     <= sj_r;
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    p2_i_r     <= p1_i_r;
    p2_j_r     <= p1_j_r;
    if (cand) begin
      best_d_r    <= p2_d;
      best_j_r    <= p2_j_r;
      best_dsat_r <= p2_dsat;
    end
    if (row_done) begin
      match_mem[p2_i_r] <= {row_j, row_dsat};
    end
    match_rd_r <= match_mem[k_r];
    if (out_load) begin
      out_hit_r     <= IDX_W'(k_r);
      out_matched_r <= flag_r[k_r];
      out_sim_r     <= flag_r[k_r] ? IDX_W'(match_rd_r[SIW+DIST_W-1:DIST_W]) : '0;
      out_dist_r    <= flag_r[k_r] ? match_rd_r[DIST_W-1:0] : '0;
      out_ovf_r     <= ovf_r;
      out_last_r    <= (k_inc == rcx);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit_index = out_hit_r;
  assign out_ch.matched   = out_matched_r;
  assign out_ch.sim_index = out_sim_r;
  assign out_ch.distance  = out_dist_r;
  assign out_ch.overflow  = out_ovf_r;
  assign out_ch.last      = out_last_r;

  // scan pipeline only carries pairs while a scan is in flight
  `ASSERT_IMPL(a_pipe_in_scan, p1_valid_r || p2_valid_r, (state_r == S_SCAN) || (state_r == S_DRAIN), "pair pipeline busy outside scan")
  // fill counts stay within the stores
  `ASSERT_IMPL(a_count_bound, 1'b1, (rc_r <= RCW'(MAX_RECO_HITS)) && (sc_r <= SCW'(MAX_SIM_HITS)), "store count past depth")
  // a run on an empty event empties the event at once
  `ASSERT_NEXT(a_empty_run, run_acc && (rc_r == '0), (rc_r == '0) && (sc_r == '0) && !ovf_r && (state_r == S_IDLE), "empty run left state behind")

endmodule

FILE: bench/greedy_hit_truth_matcher_test.sv
`timescale 1ns / 1ps

module greedy_hit_truth_matcher_test;
  import ghtm_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int N_SLOTS     = 32;
  localparam int WORD_BUDGET = 310;
  localparam int N_PHASES    = 6;
  // a run over full stores scans 32 x 32 pairs; a run with no reco hit
  // gives no result word to wait on, so idle this long before a reg write
  localparam int DRAIN_CYCLES = 1100;
  // covers the worst run, 32 words under the longest stall; ~50 runs
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX  = 10;

  // spare command code, dropped by the block
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PLANE_W-1:0] plane;
    logic [19:0]        u;
    logic [19:0]        v;
  } hit_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  hit_index;
    logic              matched;
    logic [IDX_W-1:0]  sim_index;
    logic [DIST_W-1:0] distance;
    logic              overflow;
    logic              last;
  } match_word_t;

  // directed table: a row either trusts the shadow matcher or pins its
  // single result word by hand
  typedef struct {
    hit_word_t   word;
    bit          pinned;
    match_word_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ghtm_in_if #(.POS_WIDTH(20)) in_ch ();
  ghtm_out_if out_ch ();

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  greedy_hit_truth_matcher dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the matcher: registers, hit stores and event flags
  // ---------------------------------------------------------------------
  logic [PLANE_W-1:0] plane_sel;
  logic [CUT_W-1:0]   cut_u;
  logic [CUT_W-1:0]   cut_v;

  logic [19:0]       reco_u [N_SLOTS];
  logic [19:0]       reco_v [N_SLOTS];
  logic [19:0]       sim_u  [N_SLOTS];
  logic [19:0]       sim_v  [N_SLOTS];
  bit                paired [N_SLOTS];
  logic [IDX_W-1:0]  paired_sim  [N_SLOTS];
  logic [DIST_W-1:0] paired_dist [N_SLOTS];
  int                reco_n;
  int                sim_n;
  bit                lost_load;

  match_word_t awaited_hits[$];   // result words still owed by the block
  match_word_t run_report[$];     // words made by the latest accepted word
  script_row_t script[$];

  int live_words;      // words the block acts on (ignored loads excluded)
  int runs_sent;
  int overflow_runs;
  int words_out;
  int hits_paired;
  int miss_count;
  int burst_left;
  int ready_tick;
  int cycles;

  match_word_t seen_word;
  match_word_t head_word;

  // |a - b| of two signed 20-bit positions; fits 20 bits unsigned
  function automatic logic [19:0] axis_gap(input logic [19:0] a, input logic [19:0] b);
    logic [20:0] d;
    d = {a[19], a} - {b[19], b};
    return d[20] ? 20'(-d) : d[19:0];
  endfunction

  function automatic string show(input match_word_t m);
    return $sformatf("hit=%0d matched=%0d sim=%0d dist=%0d ovf=%0d last=%0d",
                     m.hit_index, m.matched, m.sim_index, m.distance, m.overflow, m.last);
  endfunction

  function automatic int jitter(input int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic log_miss(input string msg);
    if (miss_count < REPORT_MAX) $display("MISMATCH %s", msg);
    miss_count++;
  endtask

  // Apply one accepted word to the shadow; a run leaves its words in
  // run_report and empties both stores.
  task automatic absorb_word(input hit_word_t w);
    bit                found;
    bit                ok;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] d;
    logic [19:0]       du;
    logic [19:0]       dv;
    int                bi;
    int                bj;
    match_word_t       r;
    run_report.delete();
    case (w.cmd)
      CMD_LOAD_RECO: begin
        if (w.plane == plane_sel) begin
          live_words++;
          if (reco_n < N_SLOTS) begin
            reco_u[reco_n] = w.u;
            reco_v[reco_n] = w.v;
            reco_n++;
          end else begin
            lost_load = 1'b1;
          end
        end
      end
      CMD_LOAD_SIM: begin
        if (w.plane == plane_sel) begin
          live_words++;
          if (sim_n < N_SLOTS) begin
            sim_u[sim_n] = w.u;
            sim_v[sim_n] = w.v;
            sim_n++;
          end else begin
            lost_load = 1'b1;
          end
        end
      end
      CMD_RUN: begin
        live_words++;
        runs_sent++;
        if (lost_load) overflow_runs++;
        for (int i = 0; i < N_SLOTS; i++) paired[i] = 1'b0;
        // greedy rounds: best unpaired reco/sim pair wins, first found on a tie;
        // a sim hit can be taken by any number of reco hits
        do begin
          found = 1'b0;
          best = '0;
          bi = 0;
          bj = 0;
          for (int i = 0; i < reco_n; i++) begin
            if (!paired[i]) begin
              for (int j = 0; j < sim_n; j++) begin
                du = axis_gap(reco_u[i], sim_u[j]);
                dv = axis_gap(reco_v[i], sim_v[j]);
                ok = 1'b1;
                d = '0;
                // a zero cut drops the axis from both the test and the sum
                if (cut_u != '0) begin
                  if (du >= cut_u) ok = 1'b0;
                  else d = d + du;
                end
                if (cut_v != '0) begin
                  if (dv >= cut_v) ok = 1'b0;
                  else d = d + dv;
                end
                if (ok && (!found || d < best)) begin
                  found = 1'b1;
                  best = d;
                  bi = i;
                  bj = j;
                end
              end
            end
          end
          if (found) begin
            paired[bi] = 1'b1;
            paired_sim[bi] = IDX_W'(bj);
            paired_dist[bi] = best;
          end
        end while (found);
        for (int i = 0; i < reco_n; i++) begin
          r.hit_index = IDX_W'(i);
          r.matched   = paired[i];
          r.sim_index = paired[i] ? paired_sim[i] : '0;
          r.distance  = paired[i] ? paired_dist[i] : '0;
          r.overflow  = lost_load;
          r.last      = (i == reco_n - 1);
          run_report = {run_report, r};
        end
        reco_n = 0;
        sim_n = 0;
        lost_load = 1'b0;
      end
      default: ;  // spare code: dropped
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Input side: one word per handshake, bursts with random gaps
  // ---------------------------------------------------------------------
  task automatic send_word(input hit_word_t w, input bit pinned, input match_word_t want);
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= w.cmd;
    in_ch.plane <= w.plane;
    in_ch.pos_u <= w.u;
    in_ch.pos_v <= w.v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // queue the expectation at the accepting edge, before any gap
    absorb_word(w);
    if (pinned) awaited_hits = {awaited_hits, want};
    else foreach (run_report[k]) awaited_hits = {awaited_hits, run_report[k]};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long run of back-to-back words
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end
  endtask

  // hold the input until every owed word is out, then idle some more
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_hits.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // APB side
  // ---------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== want) log_miss($sformatf("reg %0d read 0x%0h, want 0x%0h", idx, got, want));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] unused;
    apb_access(1'b1, idx, val, unused);
    case (idx)
      REG_DUT_PLANE: plane_sel = val[PLANE_W-1:0];
      REG_CUT_U:     cut_u = val[CUT_W-1:0];
      REG_CUT_V:     cut_v = val[CUT_W-1:0];
      default: ;
    endcase
    check_reg(idx, val);
  endtask

  // ---------------------------------------------------------------------
  // One event: sims scattered around a random point, reco hits near the
  // sims, off-plane and spare-code noise mixed in, closed by a run
  // ---------------------------------------------------------------------
  task automatic fire_event(input int n_reco, input int n_sim, input int spread);
    logic [19:0] cu;
    logic [19:0] cv;
    logic [19:0] anchor_u[$];
    logic [19:0] anchor_v[$];
    hit_word_t   w;
    int          r_left;
    int          s_left;
    int          k;
    cu = 20'($urandom);
    cv = 20'($urandom);
    for (int j = 0; j < n_sim; j++) begin
      anchor_u = {anchor_u, 20'(cu + jitter(3 * spread))};
      anchor_v = {anchor_v, 20'(cv + jitter(3 * spread))};
    end
    r_left = n_reco;
    s_left = n_sim;
    while (r_left + s_left > 0) begin
      if ($urandom_range(0, 11) == 0) begin
        // load on some other plane: must leave the stores alone
        w.cmd   = ($urandom_range(0, 1) == 0) ? CMD_LOAD_RECO : CMD_LOAD_SIM;
        w.plane = plane_sel ^ PLANE_W'($urandom_range(1, 15));
        w.u     = 20'($urandom);
        w.v     = 20'($urandom);
        send_word(w, 1'b0, '0);
      end
      if ($urandom_range(0, 39) == 0) begin
        w = {CMD_SPARE, PLANE_W'($urandom), 20'($urandom), 20'($urandom)};
        send_word(w, 1'b0, '0);
      end
      w.plane = plane_sel;
      if (s_left > 0 && (r_left == 0 || $urandom_range(0, 1) == 0)) begin
        w.cmd = CMD_LOAD_SIM;
        w.u   = anchor_u[n_sim - s_left];
        w.v   = anchor_v[n_sim - s_left];
        s_left--;
      end else begin
        w.cmd = CMD_LOAD_RECO;
        if (n_sim > 0 && $urandom_range(0, 7) != 0) begin
          k = $urandom_range(0, n_sim - 1);
          if ($urandom_range(0, 3) == 0) begin
            // sits right on a sim hit: zero distance, ties likely
            w.u = anchor_u[k];
            w.v = anchor_v[k];
          end else begin
            w.u = 20'(anchor_u[k] + jitter(spread));
            w.v = 20'(anchor_v[k] + jitter(spread));
          end
        end else begin
          w.u = 20'($urandom);
          w.v = 20'($urandom);
        end
        r_left--;
      end
      send_word(w, 1'b0, '0);
    end
    // plane and positions mean nothing to a run; randomize them anyway
    w.cmd   = CMD_RUN;
    w.plane = PLANE_W'($urandom);
    w.u     = 20'($urandom);
    w.v     = 20'($urandom);
    send_word(w, 1'b0, '0);
  endtask

  task automatic add_row(input logic [CMD_W-1:0] c, input logic [PLANE_W-1:0] p,
                         input logic [19:0] u, input logic [19:0] v);
    script_row_t row;
    row.word   = {c, p, u, v};
    row.pinned = 1'b0;
    row.want   = '0;
    script = {script, row};
  endtask

  // run closing an event with one reco hit: its single word is known by hand
  task automatic add_pin(input logic m, input logic [IDX_W-1:0] s, input logic [DIST_W-1:0] d);
    script_row_t row;
    row.word   = {CMD_RUN, 4'd0, 20'd0, 20'd0};
    row.pinned = 1'b1;
    row.want   = {5'd0, m, s, d, 1'b0, 1'b1};
    script = {script, row};
  endtask

  // ---------------------------------------------------------------------
  // Result side: check each word, stall on a rotating pattern
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_word = {out_ch.hit_index, out_ch.matched, out_ch.sim_index,
                   out_ch.distance, out_ch.overflow, out_ch.last};
      words_out++;
      if (seen_word.matched) hits_paired++;
      if (awaited_hits.size() == 0) begin
        log_miss($sformatf("word with nothing owed: %s", show(seen_word)));
      end else begin
        head_word = awaited_hits.pop_front();
        if (seen_word !== head_word)
          log_miss($sformatf("got %s / want %s", show(seen_word), show(head_word)));
      end
    end
    // modes: always ready, alternating, random, long stalls
    ready_tick++;
    case ((ready_tick / 97) % 4)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ready_tick[0];
      2:       out_ch.ready <= ($urandom_range(0, 2) != 0);
      default: out_ch.ready <= ((ready_tick % 24) < 6);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, awaited_hits.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed table, then random phases per setting
  // ---------------------------------------------------------------------
  initial begin : sequencer
    int                 quota;
    int                 spread;
    int                 nr;
    int                 ns;
    logic [PLANE_W-1:0] ph_plane;
    logic [CUT_W-1:0]   ph_cu;
    logic [CUT_W-1:0]   ph_cv;

    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_LOAD_RECO;
    in_ch.plane  = '0;
    in_ch.pos_u  = '0;
    in_ch.pos_v  = '0;
    out_ch.ready = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    plane_sel = PLANE_RST;
    cut_u = CUT_RST;
    cut_v = CUT_RST;
    reco_n = 0;
    sim_n = 0;
    lost_load = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_reg(REG_DUT_PLANE, PDATA_W'(PLANE_RST));
    check_reg(REG_CUT_U, PDATA_W'(CUT_RST));
    check_reg(REG_CUT_V, PDATA_W'(CUT_RST));

    // directed part, reset settings: plane 3, both cuts 200
    add_row(CMD_RUN, 4'd3, 20'd0, 20'd0);                 // empty event: no word
    add_row(CMD_LOAD_RECO, 4'd3, 20'd0, 20'd0);
    add_row(CMD_LOAD_SIM, 4'd3, 20'd199, 20'd0);
    add_pin(1'b1, 5'd0, 21'd199);                         // just inside the u cut
    add_row(CMD_LOAD_RECO, 4'd3, 20'd0, 20'd0);
    add_row(CMD_LOAD_SIM, 4'd3, 20'd200, 20'd0);
    add_pin(1'b0, 5'd0, 21'd0);                           // residual equal to cut
    add_row(CMD_LOAD_RECO, 4'd15, 20'h7FFFF, 20'h80000);  // other plane
    add_row(CMD_LOAD_RECO, 4'd3, 20'h7FFFF, 20'h80000);   // full-scale corners
    add_row(CMD_LOAD_SIM, 4'd0, 20'h80000, 20'h7FFFF);    // other plane
    add_row(CMD_LOAD_SIM, 4'd3, 20'h7FF9B, 20'h80032);
    add_pin(1'b1, 5'd0, 21'd150);                         // 100 in u + 50 in v
    add_row(CMD_SPARE, 4'd3, 20'hFFFFF, 20'hFFFFF);       // spare code dropped
    add_row(CMD_LOAD_RECO, 4'd3, 20'hFFFFF, 20'hFFFFF);
    add_pin(1'b0, 5'd0, 21'd0);                           // reco hit, no sim hit
    add_row(CMD_LOAD_RECO, 4'd3, 20'd0, 20'd0);           // tie: both reco hits
    add_row(CMD_LOAD_RECO, 4'd3, 20'd10, 20'd0);          // claim sim 0 at 5 um
    add_row(CMD_LOAD_RECO, 4'd3, 20'd0, 20'd300);         // v past the cut
    add_row(CMD_LOAD_SIM, 4'd3, 20'd5, 20'd0);
    add_row(CMD_LOAD_SIM, 4'd3, 20'd5, 20'd0);
    add_row(CMD_RUN, 4'd9, 20'hABCDE, 20'h12345);
    foreach (script[i]) send_word(script[i].word, script[i].pinned, script[i].want);
    settle(DRAIN_CYCLES);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          ph_plane = PLANE_W'($urandom);
          ph_cu = CUT_W'($urandom_range(20, 3000));
          ph_cv = CUT_W'($urandom_range(20, 3000));
        end
        1: begin  // both cuts off: every pair at distance 0
          ph_plane = 4'd15;
          ph_cu = '0;
          ph_cv = '0;
        end
        2: begin  // v only
          ph_plane = 4'd0;
          ph_cu = '0;
          ph_cv = CUT_W'($urandom_range(50, 1000));
        end
        3: begin  // widest cuts
          ph_plane = PLANE_W'($urandom);
          ph_cu = '1;
          ph_cv = '1;
        end
        4: begin  // 1 um cuts: only exact hits pair up
          ph_plane = PLANE_W'($urandom);
          ph_cu = CUT_W'(1);
          ph_cv = CUT_W'(1);
        end
        default: begin  // u only
          ph_plane = 4'd3;
          ph_cu = CUT_W'($urandom_range(1, 100000));
          ph_cv = '0;
        end
      endcase
      write_reg(REG_DUT_PLANE, PDATA_W'(ph_plane));
      write_reg(REG_CUT_U, PDATA_W'(ph_cu));
      write_reg(REG_CUT_V, PDATA_W'(ph_cv));

      spread = (ph_cu > ph_cv) ? int'(ph_cu) : int'(ph_cv);
      if (spread == 0) spread = 2500;
      if (spread > 300000) spread = 300000;
      spread = spread + spread / 4 + 1;

      // overflow events: both stores over the top
      if (ph == 0 || ph == 3) fire_event(34, 33, spread);

      // running total of words over the whole run, spread over the phases
      quota = WORD_BUDGET * (ph + 1) / N_PHASES;
      while (live_words < quota) begin
        if ($urandom_range(0, 9) == 0) nr = 0;
        else if ($urandom_range(0, 5) == 0) nr = $urandom_range(7, 14);
        else nr = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) ns = 0;
        else if ($urandom_range(0, 7) == 0) ns = $urandom_range(7, 12);
        else ns = $urandom_range(1, 6);
        fire_event(nr, ns, spread);
        // sometimes hold the input until the block has caught up
        if ($urandom_range(0, 4) == 0) settle(0);
      end
      settle(DRAIN_CYCLES);
    end

    settle(60);
    $display("covered %0d words over %0d runs (%0d with dropped loads), %0d cut settings",
             live_words, runs_sent, overflow_runs, N_PHASES + 1);
    $display("checked %0d result words, %0d of them paired", words_out, hits_paired);
    if (miss_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", miss_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
